[sv/rdp_pkg.sv]
`timescale 1ns / 1ps

package rdp_pkg;

    // Result kinds.
    localparam logic [2:0] KIND_VALUE   = 3'd0;
    localparam logic [2:0] KIND_LENGTH  = 3'd1;
    localparam logic [2:0] KIND_BYTE    = 3'd2;
    localparam logic [2:0] KIND_OK      = 3'd3;
    localparam logic [2:0] KIND_TRUNC   = 3'd4;
    localparam logic [2:0] KIND_INVALID = 3'd5;

    // Field type codes.
    localparam logic [2:0] TYPE_INT32   = 3'd0;
    localparam logic [2:0] TYPE_INT64   = 3'd1;
    localparam logic [2:0] TYPE_FLOAT   = 3'd2;
    localparam logic [2:0] TYPE_DOUBLE  = 3'd3;
    localparam logic [2:0] TYPE_BOOL    = 3'd4;
    localparam logic [2:0] TYPE_STRING  = 3'd5;
    localparam logic [2:0] TYPE_BLOB    = 3'd6;
    localparam logic [2:0] TYPE_INVALID = 3'd7;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FIELD_COUNT  = 3'd0;
    localparam logic [2:0] CFG_FIELD_TYPES  = 3'd1;
    localparam logic [2:0] CFG_PROJECT_MASK = 3'd2;
    localparam logic [2:0] CFG_COLUMN_MAP   = 3'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_blob;
    } rdp_in_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [3:0]  column;
        logic [63:0] value;
        logic [2:0]  field_type;
        logic        last_result;
    } rdp_out_t;

    // Bytes gathered for a fixed value, or for the length prefix of a
    // string or blob.
    function automatic logic [3:0] width_of(input logic [2:0] t);
        logic [3:0] w;
        case (t)
            TYPE_INT64:  w = 4'd8;
            TYPE_DOUBLE: w = 4'd8;
            TYPE_BOOL:   w = 4'd1;
            default:     w = 4'd4;
        endcase
        return w;
    endfunction

    function automatic logic [2:0] type_at(input logic [47:0] types, input logic [3:0] idx);
        return types[3 * idx +: 3];
    endfunction

    function automatic logic [3:0] column_at(input logic [63:0] map, input logic [3:0] idx);
        return map[4 * idx +: 4];
    endfunction

endpackage

[sv/row_deserializer_projecting_unit.sv]
`timescale 1ns / 1ps

// Row deserializer with column projection. The block takes a row blob one
// byte per request and decodes it under the schema held in the configuration
// registers (field count, 3-bit type per field, projection mask and 4-bit
// output column per field). Fixed fields are gathered little-endian; string
// and blob fields carry a 4-byte little-endian length prefix, and for a
// projected one the block emits a length result followed by one result per
// body byte. The request flagged end_of_blob also yields a status result:
// row ok, truncated or invalid type; the parse state then clears for the
// next row. Bytes after the last field are ignored, and results already
// emitted for a truncated field are left for the consumer to drop. Rate:
// one input request per cycle while the receiver does not stall; the result
// register is loaded from the input register. A request yields at most two
// results; only an end request whose byte also causes a result of its own
// (a projected value, length or body byte) does so, and it holds the result
// register until the port, one result per cycle, takes both; the request
// behind it waits in the input register. The user must write configuration
// only while no row is in flight; the block itself does not enforce it.
module row_deserializer_projecting_unit
    import rdp_pkg::*;
#(
    parameter int MAX_FIELDS = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  rdp_in_t     in_item,

    output logic        out_valid,
    input  logic        out_stall,
    output rdp_out_t    out_item
);

    localparam logic [4:0] MAX_COUNT = 5'(MAX_FIELDS);

    // Configuration registers.
    logic [4:0]  field_count_reg;
    logic [47:0] field_types_reg;
    logic [15:0] project_mask_reg;
    logic [63:0] column_map_reg;

    // Parse state.
    logic [4:0]  field_index_reg,   field_index_next;
    logic [2:0]  byte_in_field_reg, byte_in_field_next;
    logic [63:0] assembly_reg,      assembly_next;
    logic [31:0] remaining_reg,     remaining_next;
    logic        body_phase_reg,    body_phase_next;

    // Input register.
    logic        a_valid_reg;
    rdp_in_t     a_item_reg;

    // Result register: up to two results, the head in slot 0.
    rdp_out_t    b0_reg, b1_reg;
    logic [1:0]  b_cnt_reg;

    logic        out_fire;
    logic        pair_free;
    logic        take;
    logic [1:0]  n_res;
    rdp_out_t    r0, r1;

    logic [4:0]  eff_count;
    logic [3:0]  idx;
    logic [2:0]  cur_type;
    logic [3:0]  cur_col;
    logic        cur_proj;
    logic [63:0] gathered;
    logic [3:0]  k_count;
    logic [2:0]  status_type;
    rdp_out_t    cons_res;
    rdp_out_t    stat_res;
    logic        cons_emit;

    assign eff_count = (field_count_reg > MAX_COUNT) ? MAX_COUNT : field_count_reg;
    assign idx       = field_index_reg[3:0];
    assign cur_type  = type_at(field_types_reg, idx);
    assign cur_col   = column_at(column_map_reg, idx);
    assign cur_proj  = project_mask_reg[idx];
    assign gathered  = assembly_reg | ({56'd0, a_item_reg.data_byte} << {byte_in_field_reg, 3'b000});
    assign k_count   = {1'b0, byte_in_field_reg} + 4'd1;

    // Decode of the request in the input register.
    always_comb
    begin
        field_index_next   = field_index_reg;
        byte_in_field_next = byte_in_field_reg;
        assembly_next      = assembly_reg;
        remaining_next     = remaining_reg;
        body_phase_next    = body_phase_reg;
        cons_emit          = 1'b0;
        cons_res           = '0;
        cons_res.column    = cur_col;
        cons_res.field_type = cur_type;

        if (a_item_reg.byte_present && (field_index_reg < eff_count))
        begin
            if (body_phase_reg)
            begin
                cons_emit           = cur_proj;
                cons_res.result_kind = KIND_BYTE;
                cons_res.value      = {56'd0, a_item_reg.data_byte};
                remaining_next      = remaining_reg - 32'd1;
                if (remaining_next == 32'd0)
                begin
                    body_phase_next  = 1'b0;
                    field_index_next = field_index_reg + 5'd1;
                end
            end
            else if (cur_type != TYPE_INVALID)
            begin
                if (k_count < width_of(cur_type))
                begin
                    byte_in_field_next = k_count[2:0];
                    assembly_next      = gathered;
                end
                else
                begin
                    byte_in_field_next = 3'd0;
                    assembly_next      = '0;
                    cons_emit          = cur_proj;
                    if (cur_type < TYPE_STRING)
                    begin
                        cons_res.result_kind = KIND_VALUE;
                        cons_res.value = (cur_type == TYPE_BOOL) ?
                                         {63'd0, (gathered != 64'd0)} : gathered;
                        field_index_next = field_index_reg + 5'd1;
                    end
                    else
                    begin
                        cons_res.result_kind = KIND_LENGTH;
                        cons_res.value = {32'd0, gathered[31:0]};
                        if (gathered[31:0] == 32'd0)
                        begin
                            field_index_next = field_index_reg + 5'd1;
                        end
                        else
                        begin
                            remaining_next  = gathered[31:0];
                            body_phase_next = 1'b1;
                        end
                    end
                end
            end
        end

        // The status looks at the state left after this request's byte.
        status_type = type_at(field_types_reg, field_index_next[3:0]);
        stat_res    = '0;
        if (field_index_next >= eff_count)
        begin
            stat_res.result_kind = KIND_OK;
        end
        else if (!body_phase_next && (status_type == TYPE_INVALID))
        begin
            stat_res.result_kind = KIND_INVALID;
        end
        else
        begin
            stat_res.result_kind = KIND_TRUNC;
        end

        r0 = '0;
        r1 = '0;
        n_res = 2'd0;
        if (cons_emit)
        begin
            r0    = cons_res;
            n_res = 2'd1;
        end
        if (a_item_reg.end_of_blob)
        begin
            if (cons_emit)
            begin
                r1 = stat_res;
            end
            else
            begin
                r0 = stat_res;
            end
            n_res = n_res + 2'd1;
            field_index_next   = '0;
            byte_in_field_next = '0;
            assembly_next      = '0;
            remaining_next     = '0;
            body_phase_next    = 1'b0;
        end

        // Mark the last result of the request.
        if (n_res == 2'd2)
        begin
            r1.last_result = 1'b1;
        end
        else if (n_res == 2'd1)
        begin
            r0.last_result = 1'b1;
        end
    end

    assign out_valid = (b_cnt_reg != 2'd0);
    assign out_item  = b0_reg;
    assign out_fire  = out_valid && !out_stall;
    assign pair_free = (b_cnt_reg == 2'd0) || ((b_cnt_reg == 2'd1) && out_fire);
    assign take      = a_valid_reg && ((n_res == 2'd0) || pair_free);
    assign in_stall  = a_valid_reg && !take;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_count_reg  <= '0;
            field_types_reg  <= '0;
            project_mask_reg <= '0;
            column_map_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIELD_COUNT:  field_count_reg  <= cfg_data[4:0];
                CFG_FIELD_TYPES:  field_types_reg  <= cfg_data[47:0];
                CFG_PROJECT_MASK: project_mask_reg <= cfg_data[15:0];
                CFG_COLUMN_MAP:   column_map_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Parse state advances when the request in the input register is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_index_reg   <= '0;
            byte_in_field_reg <= '0;
            assembly_reg      <= '0;
            remaining_reg     <= '0;
            body_phase_reg    <= 1'b0;
        end
        else if (take)
        begin
            field_index_reg   <= field_index_next;
            byte_in_field_reg <= byte_in_field_next;
            assembly_reg      <= assembly_next;
            remaining_reg     <= remaining_next;
            body_phase_reg    <= body_phase_next;
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            a_item_reg <= in_item;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_cnt_reg <= '0;
        end
        else if (take && (n_res != 2'd0))
        begin
            b_cnt_reg <= n_res;
        end
        else if (out_fire)
        begin
            b_cnt_reg <= b_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && (n_res != 2'd0))
        begin
            b0_reg <= r0;
            b1_reg <= r1;
        end
        else if (out_fire)
        begin
            b0_reg <= b1_reg;
        end
    end

    // A status result always closes its request.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.result_kind >= KIND_OK)) |-> out_item.last_result)
        else $error("status result without last_result");

    // With two results held, only the second one closes the request.
    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        (b_cnt_reg == 2'd2) |-> (!b0_reg.last_result && b1_reg.last_result))
        else $error("result pair has wrong last_result marking");

    // A body in progress always has bytes left to come.
    a_body_left: assert property (@(posedge clk) disable iff (!rst_n)
        body_phase_reg |-> (remaining_reg != 32'd0))
        else $error("body phase with no bytes remaining");

    // The result register never holds more than two results.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        b_cnt_reg != 2'd3)
        else $error("result count out of range");

endmodule

[verif/row_result_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the row deserializer, keeps its own copy of the
// schema and the parse position, and checks every result against the
// results that the accepted requests should have caused.
module row_result_checker
    import rdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,

    input  logic        in_valid,
    input  logic        in_stall,
    input  rdp_in_t     in_item,

    input  logic        out_valid,
    input  logic        out_stall,
    input  rdp_out_t    out_item,

    output int          outstanding,
    output int          error_count
);

    logic [4:0]  schema_fields;
    logic [47:0] schema_types;
    logic [15:0] schema_proj;
    logic [63:0] schema_cols;

    logic [4:0]  cur_field;
    logic [2:0]  cur_byte;
    logic [63:0] gather;
    logic [31:0] body_left;
    logic        in_body;

    rdp_out_t    awaited_results[$];
    rdp_out_t    step_out[2];
    int          step_n;

    function automatic logic [4:0] live_fields();
        return (schema_fields > 5'd16) ? 5'd16 : schema_fields;
    endfunction

    function automatic logic [2:0] field_type_of(input logic [4:0] idx);
        logic [47:0] shifted;
        shifted = schema_types >> (3 * idx[3:0]);
        return shifted[2:0];
    endfunction

    // Bytes of a fixed value, or of the length prefix of a string or blob.
    function automatic int gather_len(input logic [2:0] ftype);
        if (ftype == TYPE_INT64 || ftype == TYPE_DOUBLE)
            return 8;
        else if (ftype == TYPE_BOOL)
            return 1;
        return 4;
    endfunction

    task automatic note_result(input logic [2:0] kind, input logic [3:0] col,
                               input logic [63:0] val, input logic [2:0] ftype);
        step_out[step_n].result_kind = kind;
        step_out[step_n].column      = col;
        step_out[step_n].value       = val;
        step_out[step_n].field_type  = ftype;
        step_out[step_n].last_result = 1'b0;
        step_n++;
    endtask

    task automatic clear_parse();
        cur_field = '0;
        cur_byte  = '0;
        gather    = '0;
        body_left = '0;
        in_body   = 1'b0;
    endtask

    // Advances the parse by one request and queues the results it causes.
    task automatic decode_request(input rdp_in_t req);
        logic [2:0]  ftype;
        logic        proj;
        logic [63:0] col_word;
        logic [3:0]  col;
        logic [63:0] word;
        logic [2:0]  status;
        step_n = 0;
        if (req.byte_present && cur_field < live_fields()) begin
            ftype    = field_type_of(cur_field);
            proj     = schema_proj[cur_field[3:0]];
            col_word = schema_cols >> (4 * cur_field[3:0]);
            col      = col_word[3:0];
            if (in_body) begin
                if (proj)
                    note_result(KIND_BYTE, col, {56'd0, req.data_byte}, ftype);
                body_left = body_left - 32'd1;
                if (body_left == 32'd0) begin
                    in_body   = 1'b0;
                    cur_field = cur_field + 5'd1;
                end
            end else if (ftype != TYPE_INVALID) begin
                gather = gather | ({56'd0, req.data_byte} << (8 * cur_byte));
                if (cur_byte + 1 < gather_len(ftype)) begin
                    cur_byte = cur_byte + 3'd1;
                end else begin
                    word     = gather;
                    cur_byte = '0;
                    gather   = '0;
                    if (ftype == TYPE_STRING || ftype == TYPE_BLOB) begin
                        if (proj)
                            note_result(KIND_LENGTH, col, {32'd0, word[31:0]}, ftype);
                        if (word[31:0] == 32'd0) begin
                            cur_field = cur_field + 5'd1;
                        end else begin
                            body_left = word[31:0];
                            in_body   = 1'b1;
                        end
                    end else begin
                        if (ftype == TYPE_BOOL)
                            word = {63'd0, |word};
                        if (proj)
                            note_result(KIND_VALUE, col, word, ftype);
                        cur_field = cur_field + 5'd1;
                    end
                end
            end
        end
        if (req.end_of_blob) begin
            if (cur_field >= live_fields())
                status = KIND_OK;
            else if (!in_body && field_type_of(cur_field) == TYPE_INVALID)
                status = KIND_INVALID;
            else
                status = KIND_TRUNC;
            note_result(status, '0, '0, '0);
            clear_parse();
        end
        if (step_n > 0)
            step_out[step_n - 1].last_result = 1'b1;
        for (int k = 0; k < step_n; k++)
            awaited_results.insert(awaited_results.size(), step_out[k]);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endtask

    task automatic check_result(input rdp_out_t got);
        rdp_out_t want;
        if (awaited_results.size() == 0) begin
            $error("unexpected result: kind %0d column %0d value %0h",
                   got.result_kind, got.column, got.value);
            error_count++;
        end else begin
            want = awaited_results.pop_front();
            compare_field("result_kind", 64'(want.result_kind), 64'(got.result_kind));
            compare_field("column", 64'(want.column), 64'(got.column));
            compare_field("value", want.value, got.value);
            compare_field("field_type", 64'(want.field_type), 64'(got.field_type));
            compare_field("last_result", 64'(want.last_result), 64'(got.last_result));
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            schema_fields = '0;
            schema_types  = '0;
            schema_proj   = '0;
            schema_cols   = '0;
            clear_parse();
            awaited_results.delete();
            outstanding <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_FIELD_COUNT:  schema_fields = cfg_data[4:0];
                    CFG_FIELD_TYPES:  schema_types  = cfg_data[47:0];
                    CFG_PROJECT_MASK: schema_proj   = cfg_data[15:0];
                    CFG_COLUMN_MAP:   schema_cols   = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                decode_request(in_item);
            if (out_valid && !out_stall)
                check_result(out_item);
            outstanding <= awaited_results.size();
        end
    end

endmodule

[verif/row_deserializer_projecting_unit_tb.sv]
`timescale 1ns / 1ps

// Top of the row deserializer testbench. This module only makes stimulus:
// it loads schemas, streams row blobs one request at a time and idles both
// sides of the block. The checker beside the block predicts and compares;
// this module reads its error count and gives the verdict.
module row_deserializer_projecting_unit_tb;
    import rdp_pkg::*;

    // Longest run of cycles in which no request and no result may move
    // before the run is declared hung.
    localparam int HANG_LIMIT     = 2000;
    localparam int MODE_REQUESTS  = 170;
    localparam int SCHEMA_REQUESTS = 30;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = CFG_FIELD_COUNT;
    logic [63:0] cfg_data = '0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    rdp_in_t     in_item = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    rdp_out_t    out_item;

    int          outstanding;
    int          error_count;

    // Chance, in percent, that the sender idles before a request and that
    // the receiver stalls in a given cycle.
    int          sender_gap_pct = 0;
    int          recv_stall_pct = 0;

    int          requests_sent = 0;
    int          hung_cycles = 0;

    // Copy of the schema that is loaded, so that rows can be shaped to it.
    logic [4:0]  sch_count = '0;
    logic [47:0] sch_types = '0;
    logic [15:0] sch_mask = '0;
    logic [63:0] sch_map = '0;

    always #2 clk = ~clk;

    row_deserializer_projecting_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item)
    );

    row_result_checker result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item),
        .outstanding(outstanding),
        .error_count(error_count)
    );

    // The receiver stalls at random, one decision per cycle.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Hang detection: any accepted request or result restarts the count.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            hung_cycles <= 0;
        else
            hung_cycles <= hung_cycles + 1;
        if (hung_cycles >= HANG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offers one request and returns at the edge that takes it. Valid is left
    // high on return; the next call either replaces the request in the same
    // step or lowers valid for a gap, so valid never toggles within a step.
    task automatic send_item(input logic [7:0] b, input logic present, input logic eob);
        rdp_in_t req;
        req.data_byte    = b;
        req.byte_present = present;
        req.end_of_blob  = eob;
        while ($urandom_range(0, 99) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (present || eob)
            requests_sent++;
    endtask

    // Holds the sender back until every awaited result has arrived, then waits
    // on so that a request that causes no result has also left the pipeline.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Loads a whole schema while the block is idle.
    task automatic load_schema(input logic [4:0] cnt, input logic [47:0] types,
                               input logic [15:0] mask, input logic [63:0] map);
        drain_results();
        write_reg(CFG_FIELD_COUNT, {59'd0, cnt});
        write_reg(CFG_FIELD_TYPES, {16'd0, types});
        write_reg(CFG_PROJECT_MASK, {48'd0, mask});
        write_reg(CFG_COLUMN_MAP, map);
        cfg_we    <= 1'b0;
        sch_count = cnt;
        sch_types = types;
        sch_mask  = mask;
        sch_map   = map;
    endtask

    // Flavor 0 is a random schema; the others pin registers to extremes.
    task automatic load_random_schema(input int flavor);
        logic [4:0]  cnt;
        logic [47:0] types;
        logic [15:0] mask;
        logic [63:0] map;
        int          pick;
        cnt  = 5'($urandom_range(1, 16));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            cnt = 5'd0;
        else if (pick == 1)
            cnt = 5'($urandom_range(17, 31));
        for (int f = 0; f < 16; f++)
        begin
            // Invalid types are kept rare so that most rows parse deep.
            if ($urandom_range(0, 19) == 0)
                types[3 * f +: 3] = TYPE_INVALID;
            else
                types[3 * f +: 3] = 3'($urandom_range(0, 6));
        end
        mask = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 2) != 0)
            mask = 16'hFFFF;
        map = {$urandom, $urandom};
        case (flavor)
            1:
            begin
                cnt  = 5'd31;
                mask = 16'hFFFF;
                map  = '1;
            end
            2:
            begin
                cnt   = 5'd16;
                types = '0;
                mask  = 16'hFFFF;
                map   = '0;
            end
            3:
            begin
                cnt   = 5'd16;
                types = '1;
                mask  = '0;
            end
            default: ;
        endcase
        load_schema(cnt, types, mask, map);
    endtask

    // Body bytes lean toward all zeros and all ones.
    function automatic logic [7:0] pick_byte();
        int p;
        p = $urandom_range(0, 3);
        if (p == 0)
            return 8'h00;
        else if (p == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Streams one row blob. Most rows follow the loaded schema with random
    // content; some are cut short, some are pure noise, and complete rows
    // may carry trailing bytes. Empty requests are sprinkled in, and now and
    // then the sender pauses until everything has drained.
    task automatic send_row();
        logic [7:0]  blob[$];
        logic [2:0]  t;
        logic [31:0] slen;
        logic        end_on_byte;
        int          live;
        int          style;
        int          len;
        int          cut;
        live        = (sch_count > 5'd16) ? 16 : sch_count;
        style       = $urandom_range(0, 99);
        end_on_byte = 1'($urandom_range(0, 1));
        if (style < 10)
        begin
            repeat ($urandom_range(1, 10)) blob.insert(blob.size(), 8'($urandom_range(0, 255)));
        end
        else
        begin
            for (int f = 0; f < live; f++)
            begin
                t = sch_types[3 * f +: 3];
                if (t == TYPE_INVALID)
                    break;
                if (t == TYPE_STRING || t == TYPE_BLOB)
                begin
                    if ($urandom_range(0, 9) == 0)
                        slen = $urandom_range(0, 40);
                    else
                        slen = $urandom_range(0, 4);
                    for (int k = 0; k < 4; k++)
                        blob.insert(blob.size(), slen[8 * k +: 8]);
                    repeat (slen) blob.insert(blob.size(), pick_byte());
                end
                else
                begin
                    if (t == TYPE_INT64 || t == TYPE_DOUBLE)
                        len = 8;
                    else if (t == TYPE_BOOL)
                        len = 1;
                    else
                        len = 4;
                    repeat (len) blob.insert(blob.size(), pick_byte());
                end
            end
            if (style < 30 && blob.size() > 0)
            begin
                cut = $urandom_range(0, blob.size() - 1);
                while (blob.size() > cut)
                    void'(blob.pop_back());
            end
            else
            begin
                repeat ($urandom_range(0, 2))
                    blob.insert(blob.size(), 8'($urandom_range(0, 255)));
            end
        end
        for (int k = 0; k < blob.size(); k++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            if ($urandom_range(0, 199) == 0)
                drain_results();
            send_item(blob[k], 1'b1, end_on_byte && (k == blob.size() - 1));
        end
        if (!end_on_byte || blob.size() == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial
    begin
        int mode_start;
        int schema_start;
        int schema_no;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_gap_pct = 20;
        recv_stall_pct = 49;

        // With the reset schema there are no fields: every byte is trailing,
        // an empty request causes nothing, and every row is ok.
        send_item(8'hA5, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h5A, 1'b0, 1'b1);

        // Bool in column 15, string in column 0, unprojected blob, int32 in
        // column 9, then a field of invalid type.
        load_schema(5'd5,
                    {33'd0, TYPE_INVALID, TYPE_INT32, TYPE_BLOB, TYPE_STRING, TYPE_BOOL},
                    16'b0000_0000_0000_1011,
                    {44'd0, 4'd3, 4'd9, 4'd5, 4'd0, 4'hF});

        // A full row: a nonzero bool folds to one, a two-byte string, an
        // empty blob, an all-ones int32, and then the invalid field, whose
        // byte is ignored.
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h02, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        repeat (4) send_item(8'h00, 1'b1, 1'b0);
        repeat (4) send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h3C, 1'b1, 1'b1);

        // The end request's byte completes the bool, so it causes both the
        // value and the truncated status.
        send_item(8'h01, 1'b1, 1'b1);

        // A string that ends after one of its five body bytes.
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h05, 1'b1, 1'b0);
        repeat (2) send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h7E, 1'b1, 1'b1);

        // A row with no byte at all is truncated at its first field.
        send_item(8'h00, 1'b0, 1'b1);

        // Random rows in three idling modes: sender light and receiver heavy,
        // then the reverse, then no idling at all.
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    sender_gap_pct = 20;
                    recv_stall_pct = 49;
                end
                1:
                begin
                    sender_gap_pct = 49;
                    recv_stall_pct = 20;
                end
                default:
                begin
                    sender_gap_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            mode_start = requests_sent;
            schema_no  = 0;
            while (requests_sent - mode_start < MODE_REQUESTS)
            begin
                load_random_schema((schema_no < 4) ? schema_no : 0);
                schema_start = requests_sent;
                while (requests_sent - schema_start < SCHEMA_REQUESTS)
                    send_row();
                schema_no++;
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (error_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
